### rtl/rxtm_pkg.sv
// rxtm_pkg: constants, types and helper functions shared by the exposure / filmic
// tone-map pipeline. No dependencies.
`timescale 1ns / 1ps

package rxtm_pkg;

    localparam int QW         = 63;                  // magnitude width of positive Q32.32 values
    localparam int OUT_W      = 33;
    localparam int QUO_W      = 32;
    localparam int DIV_BITS   = 2;                   // quotient bits resolved per stage
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int FRONT_STAGES = 8;
    localparam int N_STAGES   = FRONT_STAGES + DIV_STAGES + 2;

    localparam logic [0:0] REG_EXPOSURE_GAIN = 1'd0;
    localparam logic [0:0] REG_CURVE_SELECT  = 1'd1;

    localparam logic [QW-1:0]    GAIN_RESET = 63'd4294967296;
    localparam logic [OUT_W-1:0] Q_ONE      = 33'h1_0000_0000;
    localparam logic [QW-1:0]    Q_MAX      = {QW{1'b1}};

    // aces fit
    localparam logic [QW-1:0] ACES_P = 63'd10779361280;
    localparam logic [QW-1:0] ACES_Q = 63'd128849018;
    localparam logic [QW-1:0] ACES_R = 63'd10435450880;
    localparam logic [QW-1:0] ACES_S = 63'd2533990400;
    localparam logic [QW-1:0] ACES_T = 63'd601295421;
    // generic filmic fit
    localparam logic [QW-1:0] FILM_K = 63'd26628797235;
    localparam logic [QW-1:0] FILM_Q = 63'd2147483648;
    localparam logic [QW-1:0] FILM_S = 63'd7301444403;
    localparam logic [QW-1:0] FILM_T = 63'd257698037;

    typedef struct packed {
        logic [QW-1:0]       rem;
        logic [DIV_BITS-1:0] bits;
    } div_step_t;

    // saturating add of two non-negative values
    function automatic logic [QW-1:0] qadd_sat(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [QW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[QW] ? Q_MAX : s[QW-1:0];
    endfunction

    // DIV_BITS restoring division steps, rem < den on entry and exit
    function automatic div_step_t div_step(input logic [QW-1:0] rem, input logic [QW-1:0] den);
        div_step_t r;
        logic [QW:0] sh;
        r.rem  = rem;
        r.bits = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            sh = {r.rem, 1'b0};
            if (sh >= {1'b0, den}) begin
                sh        = sh - {1'b0, den};
                r.bits[i] = 1'b1;
            end
            r.rem = sh[QW-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/rxtm_qmul.sv
// rxtm_qmul: two-stage unsigned Q32.32 multiply, floor of product >> 32, saturating.
// Uses rxtm_pkg.
`timescale 1ns / 1ps

module rxtm_qmul (
    input  logic                     aclk,
    input  logic [1:0]               en,
    input  logic [rxtm_pkg::QW-1:0]  a,
    input  logic [rxtm_pkg::QW-1:0]  b,
    output logic [rxtm_pkg::QW-1:0]  p
);

    logic [63:0] ll_reg, ll_next;
    logic [62:0] lh_reg, lh_next;
    logic [62:0] hl_reg, hl_next;
    logic [61:0] hh_reg, hh_next;
    logic [rxtm_pkg::QW-1:0] p_reg, p_next;
    logic [63:0]  mid;
    logic [126:0] total;

    // four partial products of at most 32 x 32 bits
    assign ll_next = a[31:0] * b[31:0];
    assign lh_next = a[31:0] * b[62:32];
    assign hl_next = a[62:32] * b[31:0];
    assign hh_next = a[62:32] * b[62:32];

    always_comb begin
        mid    = {1'b0, lh_reg} + {1'b0, hl_reg};
        total  = {1'b0, hh_reg, ll_reg} + {31'b0, mid, 32'b0};
        p_next = (|total[126:95]) ? rxtm_pkg::Q_MAX : total[94:32];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en[1]) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### rtl/rxtm_div.sv
// rxtm_div: pipelined restoring divider with clamp, (num << 32) / den into [0, 1].
// Uses rxtm_pkg.
`timescale 1ns / 1ps

module rxtm_div (
    input  logic                                 aclk,
    input  logic [rxtm_pkg::DIV_STAGES+1:0]      en,
    input  logic [rxtm_pkg::QW-1:0]              num,
    input  logic [rxtm_pkg::QW-1:0]              den,
    output logic [rxtm_pkg::OUT_W-1:0]           y
);

    localparam int NS = rxtm_pkg::DIV_STAGES;

    logic [rxtm_pkg::QW-1:0]    rem_reg  [NS+1];
    logic [rxtm_pkg::QW-1:0]    den_reg  [NS+1];
    logic [rxtm_pkg::QUO_W-1:0] quo_reg  [NS+1];
    logic                       zero_reg [NS+1];
    logic                       one_reg  [NS+1];
    logic [rxtm_pkg::OUT_W-1:0] y_reg, y_next;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            zero_reg[0] <= (num == '0);
            one_reg[0]  <= (num >= den);
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_step
        rxtm_pkg::div_step_t st;
        assign st = rxtm_pkg::div_step(rem_reg[j-1], den_reg[j-1]);
        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j]  <= st.rem;
                den_reg[j]  <= den_reg[j-1];
                quo_reg[j]  <= {quo_reg[j-1][rxtm_pkg::QUO_W-rxtm_pkg::DIV_BITS-1:0], st.bits};
                zero_reg[j] <= zero_reg[j-1];
                one_reg[j]  <= one_reg[j-1];
            end
        end
    end

    always_comb begin
        if (zero_reg[NS]) begin
            y_next = '0;
        end else if (one_reg[NS]) begin
            y_next = rxtm_pkg::Q_ONE;
        end else begin
            y_next = {1'b0, quo_reg[NS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NS+1]) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

### rtl/rxtm_lane.sv
// rxtm_lane: one colour channel, exposure multiply, rational curve and divide.
// Uses rxtm_pkg, rxtm_qmul and rxtm_div.
`timescale 1ns / 1ps

module rxtm_lane (
    input  logic                               aclk,
    input  logic [rxtm_pkg::N_STAGES-1:0]      en,
    input  logic [63:0]                        x_in,
    input  logic [rxtm_pkg::QW-1:0]            gain,
    input  logic                               curve_sel,
    output logic [rxtm_pkg::OUT_W-1:0]         y
);

    logic [rxtm_pkg::QW-1:0] c_p, c_q, c_r, c_s, c_t;
    logic [rxtm_pkg::QW-1:0] x_mag, x, px, rx, num, c;
    logic [rxtm_pkg::QW-1:0] x_d1_reg, x_d2_reg, x_d3_reg;
    logic [rxtm_pkg::QW-1:0] a_reg, b_reg, den_reg, num_reg;

    always_comb begin
        if (curve_sel) begin
            c_p = rxtm_pkg::ACES_P; c_q = rxtm_pkg::ACES_Q; c_r = rxtm_pkg::ACES_R;
            c_s = rxtm_pkg::ACES_S; c_t = rxtm_pkg::ACES_T;
        end else begin
            c_p = rxtm_pkg::FILM_K; c_q = rxtm_pkg::FILM_Q; c_r = rxtm_pkg::FILM_K;
            c_s = rxtm_pkg::FILM_S; c_t = rxtm_pkg::FILM_T;
        end
    end

    // negative radiance ends at zero output, so feed zero
    assign x_mag = x_in[63] ? '0 : x_in[62:0];

    rxtm_qmul u_expo (.aclk(aclk), .en(en[1:0]), .a(x_mag), .b(gain), .p(x));
    rxtm_qmul u_px   (.aclk(aclk), .en(en[3:2]), .a(c_p), .b(x), .p(px));
    rxtm_qmul u_rx   (.aclk(aclk), .en(en[3:2]), .a(c_r), .b(x), .p(rx));
    rxtm_qmul u_num  (.aclk(aclk), .en(en[6:5]), .a(x_d3_reg), .b(a_reg), .p(num));
    rxtm_qmul u_den  (.aclk(aclk), .en(en[6:5]), .a(x_d3_reg), .b(b_reg), .p(c));

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            x_d1_reg <= x;
        end
        if (en[3]) begin
            x_d2_reg <= x_d1_reg;
        end
        if (en[4]) begin
            x_d3_reg <= x_d2_reg;
            a_reg    <= rxtm_pkg::qadd_sat(px, c_q);
            b_reg    <= rxtm_pkg::qadd_sat(rx, c_s);
        end
        if (en[7]) begin
            num_reg <= num;
            den_reg <= rxtm_pkg::qadd_sat(c, c_t);
        end
    end

    rxtm_div u_div (
        .aclk (aclk),
        .en   (en[rxtm_pkg::N_STAGES-1:rxtm_pkg::FRONT_STAGES]),
        .num  (num_reg),
        .den  (den_reg),
        .y    (y)
    );

endmodule

### rtl/rgb_exposure_filmic_tonemap.sv
// channel   | dir | handshake          | payload
// s_        | in  | s_tvalid/s_tready  | s_tdata: red_in, green_in, blue_in (64b each)
// m_        | out | m_tvalid/m_tready  | m_tdata: red_out, green_out, blue_out (33b each)
// cfg_      | in  | cfg_we             | cfg_addr index, cfg_wdata value
//
// pipeline: 8 multiply/add stages, 18 divider stages (load, 2-bit quotient steps, output register)
// one pixel per cycle sustained while m_tready stays high; each stage advances when empty or when its successor moves
// a stall at m_ holds the output register and lets earlier stages close up bubbles
// aresetn (synchronous, active low) clears valid bits and restores gain 1.0 and the aces curve
// top level of the tone-map pipeline; uses rxtm_pkg and rxtm_lane
`timescale 1ns / 1ps

module rgb_exposure_filmic_tonemap (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // red_in, green_in, blue_in
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // red_out, green_out, blue_out, zero pad
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [62:0]  cfg_wdata
);

    localparam int N = rxtm_pkg::N_STAGES;

    logic [rxtm_pkg::QW-1:0] gain_reg;
    logic                    curve_reg;
    logic [N:1]              v_reg, v_next;
    logic [N:1]              en_up;
    logic [N-1:0]            en;
    logic [rxtm_pkg::OUT_W-1:0] y_r, y_g, y_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= rxtm_pkg::GAIN_RESET;
            curve_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                rxtm_pkg::REG_EXPOSURE_GAIN: gain_reg  <= cfg_wdata;
                rxtm_pkg::REG_CURVE_SELECT:  curve_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // a stage loads when empty or when the next one moves on
    always_comb begin
        en_up[N] = !v_reg[N] || m_tready;
        for (int k = N - 1; k >= 1; k--) begin
            en_up[k] = !v_reg[k] || en_up[k+1];
        end
        v_next[1] = en_up[1] ? s_tvalid : v_reg[1];
        for (int k = 2; k <= N; k++) begin
            if (en_up[k]) begin
                v_next[k] = v_reg[k-1];
            end else begin
                v_next[k] = v_reg[k];
            end
        end
    end

    assign en = en_up;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    rxtm_lane u_red   (.aclk(aclk), .en(en), .x_in(s_tdata[63:0]),    .gain(gain_reg),
                       .curve_sel(curve_reg), .y(y_r));
    rxtm_lane u_green (.aclk(aclk), .en(en), .x_in(s_tdata[127:64]),  .gain(gain_reg),
                       .curve_sel(curve_reg), .y(y_g));
    rxtm_lane u_blue  (.aclk(aclk), .en(en), .x_in(s_tdata[191:128]), .gain(gain_reg),
                       .curve_sel(curve_reg), .y(y_b));

    assign s_tready = en_up[1];
    assign m_tvalid = v_reg[N];
    assign m_tdata  = {5'b0, y_b, y_g, y_r};

endmodule

### rtl/rxtm_checker.sv
// rxtm_checker: port-level assertions for the tone-map pipeline, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps

module rxtm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // a held result beat keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32:0] <= 33'h1_0000_0000 && m_tdata[65:33] <= 33'h1_0000_0000
                     && m_tdata[98:66] <= 33'h1_0000_0000)
        else $error("channel above one");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[103:99] == 5'b0)
        else $error("pad bits not zero");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid beat straight after reset");

endmodule

bind rgb_exposure_filmic_tonemap rxtm_checker u_rxtm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/tonemap_checker.sv
// tonemap_checker: watches the pixel stream of rgb_exposure_filmic_tonemap, predicts each
// tonemapped pixel from the exposure gain and curve choice, and counts mismatches.
// Depends on rxtm_pkg for register indexes and curve constants.
`timescale 1ns / 1ps

module tonemap_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,   // red_in, green_in, blue_in
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,   // red_out, green_out, blue_out, zero pad
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [62:0]  cfg_wdata,
    output int           fail_count,
    output int           pending
);

    localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

    logic [62:0] gain;
    logic        aces_on;
    logic [98:0] pixel_q[$];   // expected {red, green, blue}

    // floor(a*b / 2^32), saturated to the signed 64-bit range
    function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [127:0] p;
        p = (128'(a) * 128'(b)) >>> 32;
        if (p > 128'(S_MAX)) return S_MAX;
        if (p < 128'(S_MIN)) return S_MIN;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] fx_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S_MAX)) return S_MAX;
        if (s < 65'(S_MIN)) return S_MIN;
        return s[63:0];
    endfunction

    function automatic logic [32:0] tone_channel(logic signed [63:0] raw);
        logic signed [63:0] x, p, q, r, s, t, num, den;
        logic [95:0] quo;
        x = fx_mul(raw, {1'b0, gain});
        if (aces_on) begin
            p = rxtm_pkg::ACES_P; q = rxtm_pkg::ACES_Q; r = rxtm_pkg::ACES_R;
            s = rxtm_pkg::ACES_S; t = rxtm_pkg::ACES_T;
        end else begin
            p = rxtm_pkg::FILM_K; q = rxtm_pkg::FILM_Q; r = rxtm_pkg::FILM_K;
            s = rxtm_pkg::FILM_S; t = rxtm_pkg::FILM_T;
        end
        if (x <= 0) return '0;
        num = fx_mul(x, fx_add(fx_mul(p, x), q));
        den = fx_add(fx_mul(x, fx_add(fx_mul(r, x), s)), t);
        if (num <= 0) return '0;
        if (num >= den) return rxtm_pkg::Q_ONE;
        quo = {num[63:0], 32'd0} / {32'd0, den[63:0]};
        return quo[32:0];
    endfunction

    assign pending = pixel_q.size();

    always @(posedge aclk) begin
        logic [98:0] want;
        if (!aresetn) begin
            gain       <= rxtm_pkg::GAIN_RESET;
            aces_on    <= 1'b1;
            fail_count <= 0;
            pixel_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                pixel_q.push_back({tone_channel(s_tdata[63:0]), tone_channel(s_tdata[127:64]),
                                   tone_channel(s_tdata[191:128])});
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata[32:0] !== want[98:66] || m_tdata[65:33] !== want[65:33]
                            || m_tdata[98:66] !== want[32:0] || m_tdata[103:99] !== '0) begin
                        $display("%0t: pixel mismatch expected r=%h g=%h b=%h actual %h",
                                 $time, want[98:66], want[65:33], want[32:0], m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_addr == rxtm_pkg::REG_EXPOSURE_GAIN) gain <= cfg_wdata;
                else if (cfg_addr == rxtm_pkg::REG_CURVE_SELECT) aces_on <= cfg_wdata[0];
            end
        end
    end
endmodule

### sim/tb_rgb_exposure_filmic_tonemap.sv
// tb_rgb_exposure_filmic_tonemap: drives pixels and register writes into the tone-map
// pipeline under random idling; verdict comes from tonemap_checker. Needs rxtm_pkg.
`timescale 1ns / 1ps

module tb_rgb_exposure_filmic_tonemap;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_addr = rxtm_pkg::REG_EXPOSURE_GAIN;
    logic [62:0]  cfg_wdata = '0;
    int           fail_count, pending;
    int           src_idle = 0, snk_idle = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rgb_exposure_filmic_tonemap i_dut (.*);

    tonemap_checker i_check (.*);

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= snk_idle);

    function automatic logic [63:0] pick_channel();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'($signed($urandom_range(65535) << 16));
            2: return {32'd0, $urandom};
            3: return {28'd0, 4'($urandom_range(15)), $urandom};
            4: return {$urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
            default: return 64'($urandom_range(1 << 20)) << $urandom_range(40);
        endcase
    endfunction

    // valid stays high between back to back beats, drops only on idle cycles
    task automatic send_pixel(logic [63:0] r, logic [63:0] g, logic [63:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [62:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int n);
        repeat (n) send_pixel(pick_channel(), pick_channel(), pick_channel());
    endtask

    logic [62:0] gains[6] = '{63'd4294967296, 63'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'd1,
                              63'd17179869184, 63'd429496729};

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle = 23; snk_idle = 54;
        // directed: reset settings, extremes, zero, one, knee points
        send_pixel(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        send_pixel(64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd4294967296);
        send_pixel(64'd2147483648, 64'd42949672960, 64'd429496729);
        send_pixel(64'hFFFF_FFFF_0000_0000, 64'd64424509440, 64'd3);
        drain();
        write_reg(rxtm_pkg::REG_CURVE_SELECT, 63'd0);
        send_pixel(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        send_pixel(64'd1, 64'd4294967296, 64'd2147483648);
        send_pixel(64'd858993459, 64'd42949672960, 64'd100);
        drain();
        for (int k = 0; k < 6; k++) begin
            write_reg(rxtm_pkg::REG_EXPOSURE_GAIN, gains[k]);
            write_reg(rxtm_pkg::REG_CURVE_SELECT, 63'(k % 2));
            send_pixel(64'd4294967296, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF);
            send_pixel(64'd2147483648, 64'hFFFF_FFFF_FFFF_FFFF, 64'd429496729);
            random_phase(90);
            if (k == 2) begin
                src_idle = 54; snk_idle = 23;
            end
            if (k == 4) begin
                src_idle = 0; snk_idle = 0;
            end
            drain();   // sender holds off until every pixel is back
        end
        write_reg(rxtm_pkg::REG_EXPOSURE_GAIN, rxtm_pkg::GAIN_RESET);
        write_reg(rxtm_pkg::REG_CURVE_SELECT, 63'd1);
        random_phase(550);
        drain();
        write_reg(rxtm_pkg::REG_CURVE_SELECT, 63'd0);
        write_reg(rxtm_pkg::REG_EXPOSURE_GAIN, {31'd0, $urandom});
        random_phase(600);
        drain();
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
